[rtl/c8v_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package c8v_pkg;

  // bus device and crc
  localparam logic [6:0] DeviceAddr = 7'd8;
  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] AddrWr     = {DeviceAddr, 1'b0};
  localparam logic [7:0] AddrRd     = {DeviceAddr, 1'b1};

  // datapath widths
  localparam int GainW     = 9;
  localparam int OffsW     = 8;
  localparam int CellW     = 4;
  localparam int RawW      = 16;
  localparam int MulW      = RawW + GainW;    // raw * gain
  localparam int ProdW     = MulW + 2;        // raw * 4 * gain
  localparam int QuotW     = 18;              // floor(prod / 1000) + 1 fits
  localparam int RecipW    = 28;
  localparam int RecipShift = 37;
  localparam int RecipProdW = ProdW + RecipW;
  localparam int QkW       = 28;              // quotient * 1000
  localparam int OfsTermW  = 12;              // cell_count * offset
  localparam int VoltW     = 20;              // signed sum before clamp
  localparam int PipeDepth = 5;

  // floor(2^37 / 1000): estimate is exact or one low for any product below 2^27
  localparam logic [RecipW-1:0] RecipMul = 28'd137438953;
  localparam logic [QkW-1:0]    Divisor  = 28'd1000;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CfgGain   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCells  = 2'd2;

  localparam logic [GainW-1:0] GainReset  = 9'd365;
  localparam logic [OffsW-1:0] OffsReset  = 8'd0;
  localparam logic [CellW-1:0] CellsReset = 4'd15;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_BYTE_READ = 2'd1,
    OP_CELL_VOLT = 2'd2,
    OP_BATT_VOLT = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic [7:0] rx_data_first;
    logic [7:0] rx_crc_first;
    logic [7:0] rx_data_second;
    logic [7:0] rx_crc_second;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  crc_out;
    logic [15:0] data_out;
    logic        first_ok;
    logic        second_ok;
    logic [15:0] millivolts;
    logic        clamped;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  crc_out;
    logic [15:0] data_out;
    logic        first_ok;
    logic        second_ok;
  } frame_res_t;

  typedef struct packed {
    logic [GainW-1:0]        gain_uv;
    logic signed [OffsW-1:0] adc_offset;
    logic [CellW-1:0]        cell_count;
  } cfg_t;

  typedef struct packed {
    logic [PipeDepth-1:0] ld;
    logic [PipeDepth-1:0] vld;
  } pipe_ctrl_t;

  // one byte through crc-8, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    c = crc_in ^ din;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [7:0] CrcWrSeed = crc8_byte(8'h00, AddrWr);
  localparam logic [7:0] CrcRdSeed = crc8_byte(8'h00, AddrRd);

endpackage

`default_nettype wire

[rtl/c8v_crc.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8v_crc (
  input  c8v_pkg::in_item_t   item,
  output c8v_pkg::frame_res_t res
);

  logic [7:0] wr_crc;
  logic [7:0] rd_crc;
  logic [7:0] lo_crc;

  // address byte is folded into the seeds
  assign wr_crc = c8v_pkg::crc8_byte(c8v_pkg::crc8_byte(c8v_pkg::CrcWrSeed, item.target_reg),
                                     item.write_data);
  assign rd_crc = c8v_pkg::crc8_byte(c8v_pkg::CrcRdSeed, item.rx_data_first);
  assign lo_crc = c8v_pkg::crc8_byte(8'h00, item.rx_data_second);

  always_comb begin
    res.crc_out   = rd_crc;
    res.data_out  = 16'h0000;
    res.first_ok  = 1'b1;
    res.second_ok = 1'b1;
    case (item.operation)
      c8v_pkg::OP_WRITE: begin
        res.crc_out = wr_crc;
      end
      c8v_pkg::OP_BYTE_READ: begin
        res.data_out = {8'h00, item.rx_data_first};
        res.first_ok = (rd_crc == item.rx_crc_first);
      end
      c8v_pkg::OP_CELL_VOLT, c8v_pkg::OP_BATT_VOLT: begin
        res.data_out  = {item.rx_data_first, item.rx_data_second};
        res.first_ok  = (rd_crc == item.rx_crc_first);
        res.second_ok = (lo_crc == item.rx_crc_second);
      end
      default: begin
        res.crc_out = wr_crc;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/c8v_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8v_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output c8v_pkg::pipe_ctrl_t ctrl
);

  localparam int Depth = c8v_pkg::PipeDepth;

  logic [Depth-1:0] vld;
  logic [Depth-1:0] vld_next;
  logic [Depth-1:0] free;

  // a stage can take new data when empty or when its content moves on
  always_comb begin
    free[Depth-1] = !vld[Depth-1] || !out_stall;
    for (int i = Depth - 2; i >= 0; i--) begin
      free[i] = !vld[i] || free[i+1];
    end
  end

  always_comb begin
    ctrl.vld    = vld;
    ctrl.ld[0]  = in_valid && free[0];
    vld_next[0] = free[0] ? in_valid : vld[0];
    for (int i = 1; i < Depth; i++) begin
      ctrl.ld[i]  = vld[i-1] && free[i];
      vld_next[i] = free[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !free[0];
  assign out_valid = vld[Depth-1];

endmodule

`default_nettype wire

[rtl/c8v_conv.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8v_conv (
  input  logic                clk,
  input  c8v_pkg::cfg_t       cfg,
  input  c8v_pkg::pipe_ctrl_t ctrl,
  input  c8v_pkg::in_item_t   in_item,
  output c8v_pkg::out_item_t  out_item
);

  localparam int ProdW  = c8v_pkg::ProdW;
  localparam int MulW   = c8v_pkg::MulW;
  localparam int QuotW  = c8v_pkg::QuotW;
  localparam int QkW    = c8v_pkg::QkW;
  localparam int OfsW   = c8v_pkg::OfsTermW;
  localparam int VoltW  = c8v_pkg::VoltW;
  localparam int RpW    = c8v_pkg::RecipProdW;

  // stage 0: input register
  c8v_pkg::in_item_t s0_item;

  // stage 1: crc results, raw * gain, offset term
  c8v_pkg::frame_res_t s0_res;
  logic [MulW-1:0]     mul;
  logic [ProdW-1:0]    p_in;
  logic                is_volt;
  logic                is_batt;
  logic signed [OfsW-1:0] cells_s;
  logic signed [OfsW-1:0] offs_s;
  logic signed [OfsW-1:0] ofs_in;

  c8v_pkg::frame_res_t    s1_res;
  logic                   s1_volt;
  logic [ProdW-1:0]       s1_p;
  logic signed [OfsW-1:0] s1_ofs;

  // stage 2: quotient estimate
  logic [RpW-1:0]         recip_prod;
  c8v_pkg::frame_res_t    s2_res;
  logic                   s2_volt;
  logic [ProdW-1:0]       s2_p;
  logic signed [OfsW-1:0] s2_ofs;
  logic [QuotW-1:0]       s2_q;

  // stage 3: quotient * 1000
  c8v_pkg::frame_res_t    s3_res;
  logic                   s3_volt;
  logic [ProdW-1:0]       s3_p;
  logic signed [OfsW-1:0] s3_ofs;
  logic [QuotW-1:0]       s3_q;
  logic [QkW-1:0]         s3_qk;

  // stage 4: correction, offset, clamp
  logic [QkW-1:0]          rem;
  logic [QuotW-1:0]        q_fix;
  logic signed [VoltW-1:0] q_s;
  logic signed [VoltW-1:0] o_s;
  logic signed [VoltW-1:0] v;
  c8v_pkg::out_item_t      out_next;

  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      s0_item <= in_item;
    end
  end

  c8v_crc u_crc (
    .item (s0_item),
    .res  (s0_res)
  );

  assign is_volt = s0_item.operation inside {c8v_pkg::OP_CELL_VOLT, c8v_pkg::OP_BATT_VOLT};
  assign is_batt = (s0_item.operation == c8v_pkg::OP_BATT_VOLT);
  assign mul     = MulW'({s0_item.rx_data_first, s0_item.rx_data_second}) * MulW'(cfg.gain_uv);
  assign p_in    = is_batt ? {mul, 2'b00} : {2'b00, mul};
  assign cells_s = $signed(OfsW'(cfg.cell_count));
  assign offs_s  = OfsW'(cfg.adc_offset);
  assign ofs_in  = is_batt ? (cells_s * offs_s) : offs_s;

  always_ff @(posedge clk) begin
    if (ctrl.ld[1]) begin
      s1_res  <= s0_res;
      s1_volt <= is_volt;
      s1_p    <= p_in;
      s1_ofs  <= ofs_in;
    end
  end

  assign recip_prod = RpW'(s1_p) * RpW'(c8v_pkg::RecipMul);

  always_ff @(posedge clk) begin
    if (ctrl.ld[2]) begin
      s2_res  <= s1_res;
      s2_volt <= s1_volt;
      s2_p    <= s1_p;
      s2_ofs  <= s1_ofs;
      s2_q    <= recip_prod[c8v_pkg::RecipShift +: QuotW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[3]) begin
      s3_res  <= s2_res;
      s3_volt <= s2_volt;
      s3_p    <= s2_p;
      s3_ofs  <= s2_ofs;
      s3_q    <= s2_q;
      s3_qk   <= QkW'(s2_q) * c8v_pkg::Divisor;
    end
  end

  // estimate is at most one low
  assign rem   = QkW'(s3_p) - s3_qk;
  assign q_fix = s3_q + QuotW'(rem >= c8v_pkg::Divisor);
  assign q_s   = $signed(VoltW'(q_fix));
  assign o_s   = VoltW'(s3_ofs);
  assign v     = q_s + o_s;

  always_comb begin
    out_next.crc_out    = s3_res.crc_out;
    out_next.data_out   = s3_res.data_out;
    out_next.first_ok   = s3_res.first_ok;
    out_next.second_ok  = s3_res.second_ok;
    out_next.millivolts = 16'h0000;
    out_next.clamped    = 1'b0;
    if (s3_volt) begin
      if (v < 0) begin
        out_next.clamped = 1'b1;
      end else if (v > VoltW'(20'sd65535)) begin
        out_next.millivolts = 16'hFFFF;
        out_next.clamped    = 1'b1;
      end else begin
        out_next.millivolts = v[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[4]) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire

[rtl/crc8_afe_frame_check_and_voltage_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+---------------------------
// input     | in_valid / in_stall  | in_item  (c8v_pkg::in_item_t)
// output    | out_valid / out_stall| out_item (c8v_pkg::out_item_t)
// config    | cfg_we               | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each item passes five register
// stages (s0, s1, s2, s3, then the result register) and its result shows on out_valid
// once it reaches the result register; the stages hold the multiplies of the millivolt
// conversion (raw * gain, the reciprocal of 1000, quotient * 1000) and the correction step
// rst is synchronous and active high; it empties the pipeline and loads the
// calibration registers with their defaults
// a stall on the output holds the result register and fills the stages behind
// it; in_stall rises only once every stage holds an item

module crc8_afe_frame_check_and_voltage_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  c8v_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output c8v_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [c8v_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [c8v_pkg::CfgDataW-1:0]         cfg_data
);

  // calibration registers; write only while idle (the block does not enforce this)
  c8v_pkg::cfg_t       cfg;
  c8v_pkg::pipe_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_uv    <= c8v_pkg::GainReset;
      cfg.adc_offset <= c8v_pkg::OffsReset;
      cfg.cell_count <= c8v_pkg::CellsReset;
    end else if (cfg_we) begin
      // writes to the unused index are dropped
      case (cfg_index)
        c8v_pkg::CfgGain:   cfg.gain_uv    <= cfg_data[c8v_pkg::GainW-1:0];
        c8v_pkg::CfgOffset: cfg.adc_offset <= cfg_data[c8v_pkg::OffsW-1:0];
        c8v_pkg::CfgCells:  cfg.cell_count <= cfg_data[c8v_pkg::CellW-1:0];
        default: begin
        end
      endcase
    end
  end

  // valid bits and per-stage load enables
  c8v_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // crc check and millivolt conversion datapath
  c8v_conv u_conv (
    .clk      (clk),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

[rtl/c8v_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module c8v_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire c8v_pkg::out_item_t out_item
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // input backs up only behind a stalled, full output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // clamping only lands on the range ends
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.clamped |->
      (out_item.millivolts == 16'h0000 || out_item.millivolts == 16'hFFFF))
    else $error("clamped flag with value inside range");

  // reset leaves nothing on the output
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind crc8_afe_frame_check_and_voltage_top c8v_checker u_checker (.*);

`default_nettype wire

[tb/crc8_afe_frame_check_and_voltage_top_tb.sv]
`timescale 1ns / 1ps

module crc8_afe_frame_check_and_voltage_top_tb;

  // index past the three calibration registers, must be ignored
  localparam logic [c8v_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  // margin after the last result is back
  localparam int DrainCycles = 12;
  localparam int FramesPerPhase = 90;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  c8v_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  c8v_pkg::out_item_t out_item;
  logic cfg_we;
  logic [c8v_pkg::CfgIdxW-1:0] cfg_index;
  logic [c8v_pkg::CfgDataW-1:0] cfg_data;

  // testbench copy of the calibration registers
  logic [c8v_pkg::GainW-1:0] gain_cal;
  logic signed [c8v_pkg::OffsW-1:0] offset_cal;
  logic [c8v_pkg::CellW-1:0] cells_cal;

  c8v_pkg::in_item_t pending_frames[$];
  c8v_pkg::out_item_t expected_frame_results[$];

  int frames_queued;
  int frames_taken;
  int results_checked;
  int errors;
  int clamp_seen;
  int bad_crc_seen;
  int settings_used;
  int ops_seen[4];

  crc8_afe_frame_check_and_voltage_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // bit-serial crc-8, msb first, poly 0x07
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] octet);
    logic [7:0] c;
    logic fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ octet[i];
      c = {c[6:0], 1'b0} ^ (fb ? c8v_pkg::CrcPoly : 8'h00);
    end
    return c;
  endfunction

  // what the block must answer for one frame under the current calibration
  function automatic c8v_pkg::out_item_t frame_result(input c8v_pkg::in_item_t f);
    c8v_pkg::out_item_t r;
    logic [7:0] c;
    logic [15:0] raw;
    longint v;
    r = '0;
    r.first_ok = 1'b1;
    r.second_ok = 1'b1;
    if (f.operation == c8v_pkg::OP_WRITE) begin
      r.crc_out = crc8_step(crc8_step(crc8_step(8'h00, c8v_pkg::AddrWr), f.target_reg),
                            f.write_data);
    end else begin
      c = crc8_step(crc8_step(8'h00, c8v_pkg::AddrRd), f.rx_data_first);
      r.crc_out = c;
      r.first_ok = (c == f.rx_crc_first);
      if (f.operation == c8v_pkg::OP_BYTE_READ) begin
        r.data_out = {8'h00, f.rx_data_first};
      end else begin
        raw = {f.rx_data_first, f.rx_data_second};
        r.data_out = raw;
        r.second_ok = (crc8_step(8'h00, f.rx_data_second) == f.rx_crc_second);
        // floor division is exact here since the product is never negative
        if (f.operation == c8v_pkg::OP_CELL_VOLT) begin
          v = (longint'(raw) * longint'(gain_cal)) / 1000 + longint'(offset_cal);
        end else begin
          v = (longint'(raw) * 4 * longint'(gain_cal)) / 1000 +
              longint'(cells_cal) * longint'(offset_cal);
        end
        if (v < 0) begin
          r.clamped = 1'b1;
        end else if (v > 65535) begin
          r.millivolts = 16'hFFFF;
          r.clamped = 1'b1;
        end else begin
          r.millivolts = v[15:0];
        end
      end
    end
    return r;
  endfunction

  // read frame with both crc bytes correct
  function automatic c8v_pkg::in_item_t read_frame(input c8v_pkg::op_t op,
                                                   input logic [15:0] raw);
    c8v_pkg::in_item_t f;
    f.operation = op;
    f.target_reg = 8'($urandom);
    f.write_data = 8'($urandom);
    f.rx_data_first = raw[15:8];
    f.rx_data_second = raw[7:0];
    f.rx_crc_first = crc8_step(crc8_step(8'h00, c8v_pkg::AddrRd), raw[15:8]);
    f.rx_crc_second = crc8_step(8'h00, raw[7:0]);
    return f;
  endfunction

  // write frame; the receive fields carry junk the block must not look at
  function automatic c8v_pkg::in_item_t write_frame(input logic [7:0] ra,
                                                    input logic [7:0] wd);
    c8v_pkg::in_item_t f;
    f = read_frame(c8v_pkg::OP_WRITE, 16'($urandom));
    f.rx_crc_first = 8'($urandom);
    f.rx_crc_second = 8'($urandom);
    f.target_reg = ra;
    f.write_data = wd;
    return f;
  endfunction

  // mostly well-formed frames, some with damaged or random crc bytes
  function automatic c8v_pkg::in_item_t random_frame();
    c8v_pkg::in_item_t f;
    logic [15:0] raw;
    int unsigned pick;
    raw = 16'($urandom);
    pick = $urandom_range(0, 9);
    // low raw values reach clamping at zero, high ones clamping at full scale
    if (pick < 2) raw[15:8] = 8'h00;
    else if (pick == 2) raw[15:8] = 8'hFF;
    else if (pick == 3) raw[15:4] = 12'h000;
    f = read_frame(c8v_pkg::op_t'($urandom_range(0, 3)), raw);
    pick = $urandom_range(0, 9);
    if (pick == 6) begin
      f.rx_crc_first ^= 8'(1 << $urandom_range(0, 7));
    end else if (pick == 7) begin
      f.rx_crc_second ^= 8'(1 << $urandom_range(0, 7));
    end else if (pick >= 8) begin
      f.rx_crc_first = 8'($urandom);
      f.rx_crc_second = 8'($urandom);
    end
    return f;
  endfunction

  // idle length: none in calm stretches, else mostly short and now and then long
  function automatic int pick_pause(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic queue_frame(input c8v_pkg::in_item_t f);
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  // one register write; the mirror follows the block's masking rules
  task automatic write_reg(input logic [c8v_pkg::CfgIdxW-1:0] idx,
                           input logic [c8v_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      c8v_pkg::CfgGain: gain_cal = data[c8v_pkg::GainW-1:0];
      c8v_pkg::CfgOffset: offset_cal = data[c8v_pkg::OffsW-1:0];
      c8v_pkg::CfgCells: cells_cal = data[c8v_pkg::CellW-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits get random values, the block must drop them
  task automatic set_calibration(input logic [c8v_pkg::GainW-1:0] g,
                                 input logic [c8v_pkg::OffsW-1:0] o,
                                 input logic [c8v_pkg::CellW-1:0] c);
    write_reg(c8v_pkg::CfgGain, g);
    write_reg(c8v_pkg::CfgOffset, {1'($urandom), o});
    write_reg(c8v_pkg::CfgCells, {5'($urandom), c});
    settings_used++;
  endtask

  // block is idle once every queued frame is taken and every result is back
  task automatic wait_idle();
    while (!(frames_taken == frames_queued && expected_frame_results.size() == 0))
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    repeat (n) queue_frame(random_frame());
    wait_idle();
  endtask

  // frame driver: predicts on acceptance, then presents the next frame
  int frame_gap;
  bit calm_in;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      frame_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_frame_results.push_back(frame_result(in_item));
        frames_taken++;
        ops_seen[in_item.operation]++;
      end
      // a stalled frame stays put
      if (!(in_valid && in_stall)) begin
        if (frame_gap > 0) begin
          frame_gap--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          in_item <= pending_frames.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
          frame_gap = pick_pause(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  int stall_left;
  bit calm_out;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
      stall_left = pick_pause(calm_out);
    end
  end

  // result monitor: oldest expectation first, field by field
  c8v_pkg::out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_frame_results.size() == 0) begin
        flag_error($sformatf("result %h with nothing expected", out_item));
      end else begin
        want = expected_frame_results.pop_front();
        results_checked++;
        if (want.clamped) clamp_seen++;
        if (!want.first_ok || !want.second_ok) bad_crc_seen++;
        if (out_item.crc_out !== want.crc_out)
          flag_error($sformatf("crc_out %h, want %h", out_item.crc_out, want.crc_out));
        if (out_item.data_out !== want.data_out)
          flag_error($sformatf("data_out %h, want %h", out_item.data_out, want.data_out));
        if (out_item.first_ok !== want.first_ok)
          flag_error($sformatf("first_ok %b, want %b", out_item.first_ok, want.first_ok));
        if (out_item.second_ok !== want.second_ok)
          flag_error($sformatf("second_ok %b, want %b", out_item.second_ok, want.second_ok));
        if (out_item.millivolts !== want.millivolts)
          flag_error($sformatf("millivolts %0d, want %0d", out_item.millivolts,
                               want.millivolts));
        if (out_item.clamped !== want.clamped)
          flag_error($sformatf("clamped %b, want %b", out_item.clamped, want.clamped));
      end
    end
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    c8v_pkg::in_item_t f;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    // mirror starts at the reset calibration
    gain_cal = c8v_pkg::GainReset;
    offset_cal = c8v_pkg::OffsReset;
    cells_cal = c8v_pkg::CellsReset;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset calibration
    queue_frame(write_frame(8'h00, 8'h00));
    queue_frame(write_frame(8'hFF, 8'hFF));
    queue_frame(write_frame(8'h5A, 8'hA5));
    queue_frame(write_frame(8'h00, 8'hFF));
    queue_frame(read_frame(c8v_pkg::OP_BYTE_READ, 16'h0000));
    queue_frame(read_frame(c8v_pkg::OP_BYTE_READ, 16'hFF00));
    f = read_frame(c8v_pkg::OP_BYTE_READ, 16'hFFFF);
    f.rx_crc_first ^= 8'h80;
    queue_frame(f);
    // second byte and its crc are junk in a byte read
    f = read_frame(c8v_pkg::OP_BYTE_READ, 16'h3C00);
    f.rx_data_second = 8'($urandom);
    f.rx_crc_second = 8'($urandom);
    queue_frame(f);
    queue_frame(read_frame(c8v_pkg::OP_CELL_VOLT, 16'h0000));
    queue_frame(read_frame(c8v_pkg::OP_CELL_VOLT, 16'hFFFF));
    queue_frame(read_frame(c8v_pkg::OP_CELL_VOLT, 16'h00FF));
    // a bad crc is only flagged, data and voltage still come through
    f = read_frame(c8v_pkg::OP_CELL_VOLT, 16'h8000);
    f.rx_crc_first ^= 8'h01;
    queue_frame(f);
    f = read_frame(c8v_pkg::OP_CELL_VOLT, 16'h1234);
    f.rx_crc_second ^= 8'h10;
    queue_frame(f);
    queue_frame(read_frame(c8v_pkg::OP_BATT_VOLT, 16'h0000));
    queue_frame(read_frame(c8v_pkg::OP_BATT_VOLT, 16'hFFFF));
    queue_frame(read_frame(c8v_pkg::OP_BATT_VOLT, 16'h0101));
    f = read_frame(c8v_pkg::OP_BATT_VOLT, 16'hFF00);
    f.rx_crc_first = ~f.rx_crc_first;
    f.rx_crc_second = ~f.rx_crc_second;
    queue_frame(f);
    wait_idle();
    random_phase(80);

    // calibration extremes, in range and beyond
    set_calibration(9'd365, 8'sd0 - 8'sd128, 4'd1);
    random_phase(FramesPerPhase);
    set_calibration(9'd396, 8'sd127, 4'd15);
    random_phase(FramesPerPhase);
    // zero gain and zero cells drop the scale and the offset term
    set_calibration(9'd0, 8'sd0 - 8'sd128, 4'd0);
    random_phase(FramesPerPhase);
    // full-scale gain saturates the battery reading
    set_calibration(9'd511, 8'sd127, 4'd15);
    random_phase(FramesPerPhase);
    set_calibration(9'd511, 8'sd0 - 8'sd128, 4'd15);
    random_phase(FramesPerPhase);

    // random calibrations, each followed by a write to the spare index
    repeat (3) begin
      set_calibration(9'($urandom_range(365, 396)), 8'($urandom), 4'($urandom_range(1, 15)));
      write_reg(CfgSpare, 9'($urandom));
      random_phase(FramesPerPhase);
    end

    $display("covered %0d frames (%0d write, %0d byte, %0d cell, %0d battery)",
             frames_taken, ops_seen[c8v_pkg::OP_WRITE], ops_seen[c8v_pkg::OP_BYTE_READ],
             ops_seen[c8v_pkg::OP_CELL_VOLT], ops_seen[c8v_pkg::OP_BATT_VOLT]);
    $display("%0d calibrations, %0d results checked, %0d clamped, %0d with a failing crc",
             settings_used, results_checked, clamp_seen, bad_crc_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[crc8_afe_frame_check_and_voltage_top.f]
rtl/c8v_pkg.sv
rtl/c8v_crc.sv
rtl/c8v_ctrl.sv
rtl/c8v_conv.sv
rtl/crc8_afe_frame_check_and_voltage_top.sv
rtl/c8v_checker.sv
tb/crc8_afe_frame_check_and_voltage_top_tb.sv
